/* rtl/rtb_pkg.sv */
// shared types, constants and threshold function for the reciprocal tachometer
// no dependencies
`default_nettype none
package rtb_pkg;

  localparam int unsigned BAR_LEVELS_DEF = 17;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned REF_W   = 27;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned FREQ_W  = 24;
  localparam int unsigned LVL_W   = 5;
  localparam int unsigned PROD_W  = REF_W + CNT_W;  // ref_clock_hz * edges
  localparam int unsigned DVD_W   = PROD_W + 4;     // times ten
  localparam int unsigned THR_W   = 12;             // thresholds up to 2200
  localparam int unsigned LCNT_W  = 6;              // holds up to 32 levels
  localparam int unsigned ADDR_W  = 3;

  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
  localparam logic [LVL_W-1:0]  LVL_MAX  = {LVL_W{1'b1}};

  localparam logic [REF_W-1:0] REF_CLOCK_RST  = REF_W'(8000000);
  localparam logic [CNT_W-1:0] GATE_TICKS_RST = CNT_W'(4000000);

  // register indexes, decoded from paddr[2]
  localparam logic REG_REF_CLOCK  = 1'b0;
  localparam logic REG_GATE_TICKS = 1'b1;

  // one finished window handed from front to back
  typedef struct packed {
    logic [REF_W-1:0] ref_hz;
    logic [CNT_W-1:0] edge_cnt;
    logic [CNT_W-1:0] tick_cnt;
  } rtb_job_t;

  // bar threshold k in decihertz: 67, 133, ... for k = 1, 2, ...
  function automatic logic [THR_W-1:0] bar_threshold(input int unsigned k);
    return THR_W'((200 * k + 1) / 3);
  endfunction

endpackage
`default_nettype wire

/* rtl/reciprocal_tachometer_bargraph_unit.sv */
// top level of the reciprocal tachometer with bar graph output
// depends on rtb_pkg, rtb_front, rtb_queue, rtb_back
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------
//   in      | input     | in_valid / in_stall    | in_signal_edge
//   out     | output    | out_valid / out_stall  | out_freq_decihz, out_bar_level,
//           |           |                        | out_over_range
//   cfg     | input     | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// one item per cycle while in_stall is low: the front end counts every accepted tick
// a closed window passes through the window queue and the back end states multiply, load,
// the one-bit-per-cycle restoring divide (63 steps), saturate and done to the output
// in_stall rises only while the two-entry window queue is full
// synchronous active-low reset; no clearing pass, counters reset at once
`default_nettype none
module reciprocal_tachometer_bargraph_unit import rtb_pkg::*; #(
  parameter int unsigned BAR_LEVELS = BAR_LEVELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_signal_edge,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [FREQ_W-1:0]      out_freq_decihz,
  output logic [LVL_W-1:0]       out_bar_level,
  output logic                   out_over_range,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [REF_W-1:0] ref_clock_r;
  logic [CNT_W-1:0] gate_ticks_r;
  logic             cfg_wr;
  logic             in_acc;
  logic             job_push, q_pop, q_empty, q_full;
  rtb_job_t         push_job, pop_job;

  // config registers, decoded on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_clock_r  <= REF_CLOCK_RST;
      gate_ticks_r <= GATE_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_REF_CLOCK:  ref_clock_r  <= pwdata[REF_W-1:0];
        REG_GATE_TICKS: gate_ticks_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REF_CLOCK:  prdata = {{(32-REF_W){1'b0}}, ref_clock_r};
      REG_GATE_TICKS: prdata = gate_ticks_r;
      default:        prdata = '0;
    endcase
  end

  // input held off only when no room is left for a closing window
  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  rtb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_acc),
    .sig_edge     (in_signal_edge),
    .ref_clock_hz (ref_clock_r),
    .gate_ticks   (gate_ticks_r),
    .job_push     (job_push),
    .job          (push_job)
  );

  rtb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  rtb_back #(
    .BAR_LEVELS (BAR_LEVELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_freq_decihz (out_freq_decihz),
    .out_bar_level   (out_bar_level),
    .out_over_range  (out_over_range)
  );

endmodule
`default_nettype wire

/* rtl/rtb_front.sv */
// front end: window phase tracking and saturating tick, edge, gate counters
// depends on rtb_pkg
`default_nettype none
module rtb_front import rtb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             sig_edge,
  input  wire logic [REF_W-1:0] ref_clock_hz,
  input  wire logic [CNT_W-1:0] gate_ticks,
  output logic                  job_push,
  output rtb_job_t              job
);

  typedef enum logic [2:0] {
    PH_WAIT  = 3'b001,
    PH_GATE  = 3'b010,
    PH_ARMED = 3'b100
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] tick_r, tick_nxt, edge_r, edge_nxt, gate_r, gate_nxt;
  logic [CNT_W-1:0] tick_inc, edge_inc, gate_inc;

  assign tick_inc = (tick_r == CNT_MAX) ? tick_r : tick_r + 1'b1;
  assign edge_inc = (edge_r == CNT_MAX) ? edge_r : edge_r + 1'b1;
  assign gate_inc = (gate_r == CNT_MAX) ? gate_r : gate_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    edge_nxt     = edge_r;
    gate_nxt     = gate_r;
    job_push     = 1'b0;
    job.ref_hz   = ref_clock_hz;
    job.edge_cnt = sig_edge ? edge_inc : edge_r;
    job.tick_cnt = tick_inc;
    if (accept) begin
      unique case (phase_r)
        PH_GATE, PH_ARMED: begin
          tick_nxt = tick_inc;
          gate_nxt = gate_inc;
          if (sig_edge) edge_nxt = edge_inc;
          if (phase_r == PH_GATE) begin
            if (gate_inc >= gate_ticks) phase_nxt = PH_ARMED;
          end else if (sig_edge) begin
            // closing edge: hand the window to the back end
            job_push  = 1'b1;
            phase_nxt = PH_WAIT;
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
          if (sig_edge) begin
            tick_nxt  = '0;
            edge_nxt  = '0;
            gate_nxt  = '0;
            phase_nxt = PH_GATE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      tick_r  <= '0;
      edge_r  <= '0;
      gate_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      edge_r  <= edge_nxt;
      gate_r  <= gate_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/rtb_queue.sv */
// short job queue between front and back ends
// depends on rtb_pkg
`default_nettype none
module rtb_queue import rtb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire rtb_job_t push_job,
  input  wire logic     pop,
  output rtb_job_t      pop_job,
  output logic          empty,
  output logic          full
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  rtb_job_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  assign empty   = (fill_r == '0);
  assign full    = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      fill_nxt = fill_r + 1'b1;
    else if (pop && !push) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/rtb_back.sv */
// back end: multiply, restoring divide, saturate, bar level, output register
// depends on rtb_pkg
`default_nettype none
module rtb_back import rtb_pkg::*; #(
  parameter int unsigned BAR_LEVELS = BAR_LEVELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire rtb_job_t          q_job,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [FREQ_W-1:0]      out_freq_decihz,
  output logic [LVL_W-1:0]       out_bar_level,
  output logic                   out_over_range
);

  localparam int unsigned STEP_W = $clog2(DVD_W);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_LOAD = 6'b000100,
    S_DIV  = 6'b001000,
    S_SAT  = 6'b010000,
    S_DONE = 6'b100000
  } bstate_t;

  bstate_t            state_r, state_nxt;
  logic [REF_W-1:0]   ref_r;
  logic [CNT_W-1:0]   edge_r, div_r;
  logic [PROD_W-1:0]  prod_r;
  logic [CNT_W:0]     rem_r, rem_sh;
  logic [DVD_W-1:0]   quo_r;
  logic [STEP_W-1:0]  step_r;
  logic [FREQ_W-1:0]  freq_r;
  logic               q_bit;
  logic               out_valid_r;
  logic [FREQ_W-1:0]  out_freq_r;
  logic [LVL_W-1:0]   out_lvl_r;
  logic               out_over_r;
  logic               out_free;
  logic               over;
  logic [LCNT_W-1:0]  lvl_cnt;
  logic [LVL_W-1:0]   lvl;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;

  // one quotient bit per cycle
  assign rem_sh = {rem_r[CNT_W-1:0], quo_r[DVD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_r});

  // bar level from the saturated frequency
  always_comb begin
    over    = ({{(FREQ_W-THR_W){1'b0}}, bar_threshold(BAR_LEVELS + 1)} <= freq_r);
    lvl_cnt = '0;
    for (int unsigned k = 1; k <= BAR_LEVELS; k++) begin
      if ({{(FREQ_W-THR_W){1'b0}}, bar_threshold(k)} <= freq_r) lvl_cnt = lvl_cnt + 1'b1;
    end
    if (over)                         lvl = '0;
    else if (lvl_cnt > LCNT_W'(LVL_MAX)) lvl = LVL_MAX;
    else                              lvl = lvl_cnt[LVL_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (step_r == '0) state_nxt = S_SAT;
      S_SAT:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        ref_r  <= q_job.ref_hz;
        edge_r <= q_job.edge_cnt;
        div_r  <= q_job.tick_cnt;
      end
      S_MUL: prod_r <= PROD_W'(ref_r) * PROD_W'(edge_r);
      S_LOAD: begin
        // times ten as 8x + 2x
        quo_r  <= DVD_W'({prod_r, 3'b000}) + DVD_W'({prod_r, 1'b0});
        rem_r  <= '0;
        step_r <= STEP_W'(DVD_W - 1);
      end
      S_DIV: begin
        rem_r  <= q_bit ? rem_sh - {1'b0, div_r} : rem_sh;
        quo_r  <= {quo_r[DVD_W-2:0], q_bit};
        step_r <= step_r - 1'b1;
      end
      S_SAT: begin
        priority if (div_r == '0)              freq_r <= '0;
        else if (quo_r[DVD_W-1:FREQ_W] != '0) freq_r <= FREQ_MAX;
        else                                   freq_r <= quo_r[FREQ_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_freq_r <= freq_r;
      out_lvl_r  <= lvl;
      out_over_r <= over;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                  out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_freq_decihz = out_freq_r;
  assign out_bar_level   = out_lvl_r;
  assign out_over_range  = out_over_r;

endmodule
`default_nettype wire

/* rtl/rtb_checker.sv */
// port-level checks for the reciprocal tachometer, bound to the top level
// depends on rtb_pkg
`default_nettype none
module rtb_checker import rtb_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [FREQ_W-1:0] out_freq_decihz,
  input wire logic [LVL_W-1:0]  out_bar_level,
  input wire logic              out_over_range
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_freq_decihz)
      && $stable(out_bar_level) && $stable(out_over_range))
    else $error("stalled result changed");

  // over range blanks the bar
  a_over_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_over_range |-> out_bar_level == '0)
    else $error("bar lit while over range");

  // zero frequency shows nothing
  a_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_freq_decihz == '0 |-> out_bar_level == '0 && !out_over_range)
    else $error("zero frequency with bar or over range");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind reciprocal_tachometer_bargraph_unit rtb_checker u_rtb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_freq_decihz (out_freq_decihz),
  .out_bar_level   (out_bar_level),
  .out_over_range  (out_over_range)
);
`default_nettype wire

/* verif/tb.sv */
// self-checking testbench for reciprocal_tachometer_bargraph_unit
// depends on rtb_pkg and the tachometer rtl; a directed table, then random windows
// under changing register settings, each reading checked against its typed value or a frequency predictor
`default_nettype none
module tb import rtb_pkg::*;;

  localparam int unsigned LEVELS      = BAR_LEVELS_DEF;
  localparam int unsigned SETTLE      = 100;  // quiet time for the back end after the last reading
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES      = 24;
  localparam int unsigned ROWS        = 32;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [LVL_W-1:0]  lvl;
    logic              over;
  } reading_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        sel;    // register for write rows
    logic [31:0] value;
    logic        sig;    // edge flag for item rows
    logic        typed;  // reading written into the table
    reading_t    want;
  } row_t;

  typedef enum logic [1:0] {WIN_IDLE, WIN_GATING, WIN_ARMED} win_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_signal_edge;
  logic              out_valid;
  logic              out_stall;
  logic [FREQ_W-1:0] out_freq_decihz;
  logic [LVL_W-1:0]  out_bar_level;
  logic              out_over_range;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  reciprocal_tachometer_bargraph_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_signal_edge (in_signal_edge),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_freq_decihz(out_freq_decihz),
    .out_bar_level  (out_bar_level),
    .out_over_range (out_over_range),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: window tracker plus its own copy of the two registers
  win_t             win_state;
  logic [CNT_W-1:0] win_ticks;
  logic [CNT_W-1:0] win_edges;
  logic [CNT_W-1:0] win_gate;
  logic [REF_W-1:0] meter_hz;
  logic [CNT_W-1:0] meter_gate;

  reading_t    due_readings[$];
  int unsigned mismatches;

  // idling knobs, percent chance per item or cycle; shared with the result side
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;
  logic        rx_hold_req;

  // bar threshold k in decihertz, rounded down from 200k/3 + 1/3
  function automatic logic [63:0] bar_step(int unsigned k);
    return (64'd200 * 64'(k) + 64'd1) / 64'd3;
  endfunction

  function automatic reading_t reading_of(logic [REF_W-1:0] hz, logic [CNT_W-1:0] ev,
                                          logic [CNT_W-1:0] tk);
    logic [63:0] q;
    reading_t    r;
    q = 64'd0;
    if (tk != '0) begin
      q = (64'(hz) * 64'(ev) * 64'd10) / 64'(tk);
      if (q > 64'(FREQ_MAX)) q = 64'(FREQ_MAX);
    end
    r.freq = q[FREQ_W-1:0];
    r.over = (q >= bar_step(LEVELS + 1));
    r.lvl  = '0;
    if (!r.over) begin
      for (int unsigned k = 1; k <= LEVELS; k++) begin
        if (q >= bar_step(k)) r.lvl = LVL_W'((k > 31) ? 31 : k);
      end
    end
    return r;
  endfunction

  // one reference tick
  task automatic meter_step(input logic e, output logic fired, output reading_t r);
    fired   = 1'b0;
    r       = '0;
    if (win_state != WIN_GATING && win_state != WIN_ARMED) begin
      win_state = WIN_IDLE;
      if (e) begin
        win_ticks = '0;
        win_edges = '0;
        win_gate  = '0;
        win_state = WIN_GATING;
      end
      return;
    end
    if (win_ticks != CNT_MAX) win_ticks++;
    if (win_gate != CNT_MAX) win_gate++;
    if (e && win_edges != CNT_MAX) win_edges++;
    if (win_state == WIN_GATING) begin
      if (win_gate >= meter_gate) win_state = WIN_ARMED;
      return;
    end
    if (!e) return;
    win_state = WIN_IDLE;
    fired     = 1'b1;
    r         = reading_of(meter_hz, win_edges, win_ticks);
  endtask

  // offer one item, wait for it to be taken, then advance the predictor
  task automatic send_item(input logic e, output logic fired, output reading_t r);
    if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_signal_edge <= e;
    do @(posedge clk); while (in_stall);
    meter_step(e, fired, r);
  endtask

  // stop offering items until every reading is back and the divider is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic sel, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_REF_CLOCK) meter_hz = v[REF_W-1:0];
    else meter_gate = v;
    @(posedge clk);
  endtask

  function automatic row_t item_row(logic e);
    item_row      = '0;
    item_row.kind = ROW_ITEM;
    item_row.sig  = e;
  endfunction

  function automatic row_t check_row(logic e, int unsigned f, int unsigned l, logic o);
    check_row           = item_row(e);
    check_row.typed     = 1'b1;
    check_row.want.freq = FREQ_W'(f);
    check_row.want.lvl  = LVL_W'(l);
    check_row.want.over = o;
  endfunction

  function automatic row_t write_row(logic s, logic [31:0] v);
    write_row       = '0;
    write_row.kind  = ROW_WRITE;
    write_row.sel   = s;
    write_row.value = v;
  endfunction

  // edge density of the next window, per mille
  function automatic int unsigned window_density();
    case ($urandom_range(0, 3))
      0: return $urandom_range(20, 150);
      1: return $urandom_range(150, 600);
      2: return $urandom_range(600, 1000);
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // result side: checks every taken reading and stalls in bursts or one long hold
  initial begin : result_side
    reading_t    got;
    reading_t    want;
    int unsigned burst;
    int unsigned hold_left;
    burst     = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.freq = out_freq_decihz;
        got.lvl  = out_bar_level;
        got.over = out_over_range;
        if (due_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected reading freq %0d level %0d over %0d",
                     got.freq, got.lvl, got.over);
        end else begin
          want = due_readings.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: freq %0d/%0d level %0d/%0d over %0d/%0d (expected/actual)",
                       want.freq, got.freq, want.lvl, got.lvl, want.over, got.over);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_hold_req) begin
        // long hold so the window queue fills and the input side backs up
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES - 1;
        out_stall   <= 1'b1;
      end else if (burst != 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
        burst     = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus side
  initial begin : stimulus
    row_t        script [ROWS];
    int unsigned dens;
    int unsigned quota;
    int unsigned counted_n;
    logic [31:0] hz;
    logic [31:0] gate;
    logic        e;
    logic        fired;
    reading_t    r;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_signal_edge <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    mismatches   = 0;
    rx_hold_req  = 1'b0;
    tx_gap_pct   = 15;
    rx_stall_pct = 15;
    win_state    = WIN_IDLE;
    win_ticks    = '0;
    win_edges    = '0;
    win_gate     = '0;
    meter_hz     = REF_CLOCK_RST;
    meter_gate   = GATE_TICKS_RST;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part; each window closes with one typed reading
    script = '{
      item_row(1'b0),                       // idle tick at reset settings
      item_row(1'b1),                       // opens a window with the long default gate
      write_row(REG_REF_CLOCK, 32'd100),
      write_row(REG_GATE_TICKS, 32'd2),
      item_row(1'b0),
      item_row(1'b0),
      check_row(1'b1, 333, 5, 1'b0),        // exactly on the fifth threshold
      item_row(1'b1),
      item_row(1'b1),                       // edges inside the gate are counted
      item_row(1'b1),
      check_row(1'b1, 1000, 15, 1'b0),      // exactly on the fifteenth threshold
      write_row(REG_REF_CLOCK, 32'd120),
      write_row(REG_GATE_TICKS, 32'd0),     // zero gate acts as one tick
      item_row(1'b1),
      item_row(1'b0),
      check_row(1'b1, 600, 9, 1'b0),
      write_row(REG_GATE_TICKS, 32'd1),
      item_row(1'b1),
      item_row(1'b1),
      check_row(1'b1, 1200, 0, 1'b1),       // 120.0 Hz is already over range
      write_row(REG_REF_CLOCK, 32'd227),
      item_row(1'b1),
      item_row(1'b0),
      check_row(1'b1, 1135, 17, 1'b0),      // full bar just below over range
      write_row(REG_REF_CLOCK, 32'd100000000),
      item_row(1'b1),
      item_row(1'b0),
      check_row(1'b1, 16777215, 0, 1'b1),   // frequency saturates
      write_row(REG_REF_CLOCK, 32'd0),
      item_row(1'b1),
      item_row(1'b0),
      check_row(1'b1, 0, 0, 1'b0)           // zero reference clock reads zero
    };
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle();
        write_reg(script[i].sel, script[i].value);
      end else begin
        send_item(script[i].sig, fired, r);
        if (script[i].typed) due_readings.push_back(script[i].want);
        else if (fired) due_readings.push_back(r);
      end
    end

    // random part: one register setting per phase, edges drawn per window
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      quota = 78;
      case (ph)
        0: begin
          hz    = $urandom_range(0, 32'h7FF_FFFF);  // every register bit, no window closes
          gate  = 32'hFFFF_FFFF;
          quota = 40;
        end
        1: begin
          hz   = 32'd100000000;
          gate = $urandom_range(1, 8);
        end
        2: begin
          hz   = 32'd0;
          gate = $urandom_range(1, 8);
        end
        3: begin
          hz   = $urandom_range(60, 240);
          gate = 32'd0;
        end
        4: begin
          hz   = $urandom_range(90, 150);
          gate = 32'd1;
        end
        default: begin
          case ($urandom_range(0, 5))
            0: begin
              hz   = $urandom_range(1, 100000000);
              gate = $urandom_range(1, 6);
            end
            1, 2: begin
              hz   = $urandom_range(1, 250);
              gate = $urandom_range(1, 16);
            end
            3: begin
              hz   = $urandom_range(1, 30);
              gate = $urandom_range(40, 200);
            end
            4: begin
              hz   = $urandom_range(100, 140);
              gate = $urandom_range(0, 3);
            end
            default: begin
              hz   = $urandom_range(1, 400);
              gate = $urandom_range(1, 40);
            end
          endcase
        end
      endcase

      settle();
      write_reg(REG_REF_CLOCK, hz);
      write_reg(REG_GATE_TICKS, gate);

      // no idling in phase 4 (long hold) nor in the closing phases
      if (ph == 4 || ph >= PHASES - 2) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct   = 15 * $urandom_range(0, 2);
        rx_stall_pct = 15 * $urandom_range(0, 2);
      end

      dens = window_density();
      if (ph == 4) begin
        dens        = 900;
        rx_hold_req = 1'b1;
      end

      // every item sent counts toward the phase quota
      counted_n = 0;
      while (counted_n < quota) begin
        e = ($urandom_range(0, 999) < dens);
        send_item(e, fired, r);
        counted_n++;
        if (fired) begin
          due_readings.push_back(r);
          if (ph != 4) dens = window_density();
        end
      end
    end

    settle();
    if (due_readings.size() != 0) begin
      mismatches++;
      $display("mismatch: %0d readings never arrived", due_readings.size());
    end
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin : run_limit
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
